// ===== hdl/pid_antiwindup_controller_top_macros.svh =====
// assertion macros for the pid controller
`ifndef PID_ANTIWINDUP_CONTROLLER_TOP_MACROS_SVH
`define PID_ANTIWINDUP_CONTROLLER_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define PID_ASSERT_IMP(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define PID_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);
`endif

// ===== hdl/pid_pkg.sv =====
// package for the pid controller: payload types, codes, states
`default_nettype none
package pid_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int TIME_WIDTH = 24;
    localparam int ACC_WIDTH  = 48;
    localparam int CFG_WIDTH  = 48;
    localparam int IDX_WIDTH  = 3;
    // wide working width for products and serial division
    localparam int WORK_WIDTH = 96;
    localparam int CNT_WIDTH  = 7;

    localparam logic [IDX_WIDTH-1:0] REG_TARGET = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_GAIN_P = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_GAIN_I = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_GAIN_D = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_LIMIT  = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_BOUND  = 3'd5;

    localparam logic [1:0] FUNC_DERIVE = 2'd0;
    localparam logic [1:0] FUNC_SUPPLY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    // spare code, acts as a clear
    localparam logic [1:0] FUNC_SPARE  = 2'd3;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [DATA_WIDTH-1:0] measurement;
        logic signed [DATA_WIDTH-1:0] rate;
        logic [TIME_WIDTH-1:0]        elapsed_us;
    } pid_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         held;
        logic                         limited;
    } pid_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RATE_DIV, ST_RESP_I, ST_RESP_D, ST_RESP_P, ST_RESP_DONE,
        ST_INT_DIV, ST_INT_UPD, ST_OUT, ST_DONE
    } pid_state_t;

    // serial unit job: multiply then divide
    typedef enum logic [1:0] {
        JOB_DIV_ELAPSED, JOB_DIV_MEGA, JOB_MUL_Q
    } pid_job_t;
endpackage
`default_nettype wire

// ===== hdl/pid_antiwindup_controller_top.sv =====
// top level of the pid controller with anti-windup
`default_nettype none
// Q16.16 pid controller with anti-windup. Each transfer on s_ carries one
// update (or a clear); exactly one result transfer follows on m_. For a clear
// or a zero elapsed time the result is set valid by the ST_DONE state.
// An update runs through one shared bit-serial unit: every operation forms
// |a|*|b| one multiplier bit per cycle and then divides the product one
// quotient bit per cycle. An update with derived rate needs eight operations
// and four steps outside the unit; with a supplied rate seven operations.
// The next input is taken once the result transfer is done. Configuration
// is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while the block is idle, the block itself does not enforce it.
module pid_antiwindup_controller_top (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  pid_pkg::pid_in_t            s_data,
    output logic                        m_valid,
    input  wire                         m_ready,
    output pid_pkg::pid_out_t           m_data,
    input  wire                         cfg_we,
    input  wire [pid_pkg::IDX_WIDTH-1:0] cfg_index,
    input  wire [pid_pkg::CFG_WIDTH-1:0] cfg_data
);
    import pid_pkg::*;

    localparam logic [63:0] BIG_MAG = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] DAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [31:0] US_PER_S = 32'd1000000;

    // configuration registers
    logic signed [DATA_WIDTH-1:0] target_reg, gain_p_reg, gain_i_reg, gain_d_reg, limit_reg;
    logic signed [ACC_WIDTH-1:0]  bound_reg;
    // controller state
    logic signed [ACC_WIDTH-1:0]  integ_reg;
    logic signed [DATA_WIDTH-1:0] prev_reg, last_reg;
    // per-item working registers
    pid_state_t state_reg, state_next;
    pid_in_t    item_reg;
    logic signed [DATA_WIDTH-1:0] err_reg, rate_reg;
    logic signed [ACC_WIDTH-1:0]  ti_reg, td_reg;
    logic       second_reg;
    pid_out_t   out_reg;
    logic       out_valid_reg;

    // serial unit: shift-add multiply, then restoring divide of the product
    logic [63:0]          ma_reg;   // multiplicand magnitude
    logic [63:0]          mb_reg;   // multiplier magnitude, shifted out lsb first
    logic [WORK_WIDTH-1:0] prod_reg; // product, then dividend shifted out msb first
    logic [WORK_WIDTH-1:0] quo_reg;
    logic [32:0]          rem_reg;
    logic [31:0]          div_reg;
    logic                 neg_reg;
    logic                 phase_reg; // 0 multiply, 1 divide
    logic                 busy_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic                 start;
    logic signed [63:0]   op_a, op_b;
    logic [31:0]          op_d;
    logic signed [63:0]   unit_res;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [63:0] v);
        if (v > 64'(ACC_MAX))      sat_acc = ACC_MAX;
        else if (v < 64'(ACC_MIN)) sat_acc = ACC_MIN;
        else                       sat_acc = v[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_dat(input logic signed [63:0] v);
        if (v > 64'(DAT_MAX))      sat_dat = DAT_MAX;
        else if (v < 64'(DAT_MIN)) sat_dat = DAT_MIN;
        else                       sat_dat = v[DATA_WIDTH-1:0];
    endfunction

    // signed result of the serial unit, magnitude capped
    logic [WORK_WIDTH-1:0] q_cap;
    always_comb begin
        q_cap = quo_reg;
        if (q_cap > WORK_WIDTH'(BIG_MAG)) q_cap = WORK_WIDTH'(BIG_MAG);
        unit_res = neg_reg ? -$signed(q_cap[63:0]) : $signed(q_cap[63:0]);
    end

    logic unit_done;
    assign unit_done = busy_reg && phase_reg && (cnt_reg == '0);

    logic [32:0] rem_try;
    assign rem_try = {rem_reg[31:0], prod_reg[WORK_WIDTH-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            ma_reg    <= mag64(op_a);
            mb_reg    <= mag64(op_b);
            neg_reg   <= (op_a < 0) != (op_b < 0);
            div_reg   <= op_d;
            prod_reg  <= '0;
            cnt_reg   <= CNT_WIDTH'(64);
        end else if (busy_reg && !phase_reg) begin
            // one multiplier bit per cycle
            if (mb_reg[0]) prod_reg <= prod_reg + (WORK_WIDTH'(ma_reg) << (7'd64 - cnt_reg));
            mb_reg  <= mb_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1)) begin
                phase_reg <= 1'b1;
                cnt_reg   <= CNT_WIDTH'(WORK_WIDTH);
                rem_reg   <= '0;
                quo_reg   <= '0;
            end
        end else if (busy_reg && cnt_reg != '0) begin
            // one quotient bit per cycle
            prod_reg <= prod_reg << 1;
            cnt_reg  <= cnt_reg - 1'b1;
            if (rem_try >= {1'b0, div_reg}) begin
                rem_reg <= rem_try - {1'b0, div_reg};
                quo_reg <= {quo_reg[WORK_WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[WORK_WIDTH-2:0], 1'b0};
            end
        end else if (busy_reg) begin
            busy_reg <= 1'b0;
        end
    end

    // input transfer only when idle and the result register is free
    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    logic s_take;
    assign s_take = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    if (s_data.func[1] || s_data.elapsed_us == '0) state_next = ST_DONE;
                    else if (s_data.func == FUNC_DERIVE)            state_next = ST_RATE_DIV;
                    else                                            state_next = ST_RESP_I;
                end
            end
            ST_RATE_DIV: if (unit_done) state_next = ST_RESP_I;
            ST_RESP_I:   if (unit_done) state_next = ST_RESP_D;
            ST_RESP_D:   if (unit_done) state_next = ST_RESP_P;
            ST_RESP_P:   if (unit_done) state_next = ST_RESP_DONE;
            ST_RESP_DONE: state_next = second_reg ? ST_OUT : ST_INT_DIV;
            ST_INT_DIV:  if (unit_done) state_next = ST_INT_UPD;
            ST_INT_UPD:  state_next = ST_RESP_I;
            ST_OUT:      state_next = ST_IDLE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // operand selection for the serial unit
    logic signed [63:0] resp_sum;
    assign resp_sum = 64'(sat_acc(64'(err_reg) + 64'(ti_reg) + 64'(td_reg)));
    always_comb begin
        start = 1'b0;
        op_a  = '0;
        op_b  = '0;
        op_d  = 32'd65536;
        if (!busy_reg && !unit_done) begin
            case (state_reg)
                ST_RATE_DIV: begin
                    start = 1'b1;
                    op_a  = 64'(item_reg.measurement) - 64'(prev_reg);
                    op_b  = 64'(US_PER_S);
                    op_d  = 32'(item_reg.elapsed_us);
                end
                ST_RESP_I: begin
                    start = 1'b1;
                    op_a  = 64'(gain_i_reg);
                    op_b  = 64'(integ_reg);
                end
                ST_RESP_D: begin
                    start = 1'b1;
                    op_a  = 64'(gain_d_reg);
                    op_b  = 64'(rate_reg);
                end
                ST_RESP_P: begin
                    start = 1'b1;
                    op_a  = 64'(gain_p_reg);
                    op_b  = resp_sum;
                end
                ST_INT_DIV: begin
                    start = 1'b1;
                    op_a  = 64'(err_reg);
                    op_b  = 64'(item_reg.elapsed_us);
                    op_d  = US_PER_S;
                end
                default: start = 1'b0;
            endcase
        end
    end

    logic signed [DATA_WIDTH-1:0] resp_reg;
    logic [63:0] resp_mag;
    assign resp_mag = mag64(64'(resp_reg));
    logic windup_ok;
    assign windup_ok = limit_reg[DATA_WIDTH-1] || (resp_mag < 64'(limit_reg)) ||
                       (integ_reg != '0 && (integ_reg[ACC_WIDTH-1] != err_reg[DATA_WIDTH-1]));
    logic signed [ACC_WIDTH-1:0] integ_add;
    assign integ_add = sat_acc(64'(integ_reg) + unit_res);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            gain_p_reg    <= DATA_WIDTH'(65536);
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            limit_reg     <= -DATA_WIDTH'(65536);
            bound_reg     <= '1;
            integ_reg     <= '0;
            prev_reg      <= '0;
            last_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET: target_reg <= cfg_data[DATA_WIDTH-1:0];
                    REG_GAIN_P: gain_p_reg <= cfg_data[DATA_WIDTH-1:0];
                    REG_GAIN_I: gain_i_reg <= cfg_data[DATA_WIDTH-1:0];
                    REG_GAIN_D: gain_d_reg <= cfg_data[DATA_WIDTH-1:0];
                    REG_LIMIT:  limit_reg  <= cfg_data[DATA_WIDTH-1:0];
                    REG_BOUND:  bound_reg  <= cfg_data[ACC_WIDTH-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_take) begin
                        item_reg   <= s_data;
                        second_reg <= 1'b0;
                        err_reg    <= sat_dat(64'(target_reg) - 64'(s_data.measurement));
                        rate_reg   <= s_data.rate;
                        if (s_data.func[1]) begin
                            integ_reg <= '0;
                            prev_reg  <= '0;
                            last_reg  <= '0;
                            out_reg   <= '{drive: '0, held: 1'b0, limited: 1'b0};
                        end else if (s_data.elapsed_us == '0) begin
                            out_reg   <= '{drive: last_reg, held: 1'b1, limited: 1'b0};
                        end
                    end
                end
                ST_RATE_DIV: if (unit_done) rate_reg <= sat_dat(unit_res);
                ST_RESP_I:   if (unit_done) ti_reg <= sat_acc(unit_res);
                ST_RESP_D:   if (unit_done) td_reg <= sat_acc(unit_res);
                ST_RESP_P:   if (unit_done) resp_reg <= sat_dat(unit_res);
                ST_RESP_DONE: second_reg <= 1'b1;
                ST_INT_UPD: begin
                    // anti-windup gate, then the bound clamp
                    logic signed [ACC_WIDTH-1:0] nxt;
                    nxt = windup_ok ? integ_add : integ_reg;
                    if (!bound_reg[ACC_WIDTH-1] && gain_i_reg > 0) begin
                        if (nxt > bound_reg)       nxt = bound_reg;
                        else if (nxt < -bound_reg) nxt = -bound_reg;
                    end
                    integ_reg <= nxt;
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    // the rate derivation has used the old value by now
                    prev_reg      <= item_reg.measurement;
                    if (!limit_reg[DATA_WIDTH-1] && resp_mag >= 64'(limit_reg)) begin
                        logic signed [DATA_WIDTH-1:0] c;
                        c = resp_reg[DATA_WIDTH-1] ? -limit_reg : limit_reg;
                        out_reg  <= '{drive: c, held: 1'b0, limited: 1'b1};
                        last_reg <= c;
                    end else begin
                        out_reg  <= '{drive: resp_reg, held: 1'b0, limited: 1'b0};
                        last_reg <= resp_reg;
                    end
                end
                ST_DONE: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

`include "pid_antiwindup_controller_top_macros.svh"
    `PID_ASSERT_IMP(a_no_take_busy, aclk, aresetn, busy_reg, !s_ready, "input taken while unit busy")
    `PID_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed")
    `PID_ASSERT_IMP(a_no_start_busy, aclk, aresetn, start, !busy_reg, "unit restarted while busy")
endmodule
`default_nettype wire
